[rtl/sdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_pkg
// Types, constants and the arctangent table for the stick dead-zone and
// direction core.
// ----------------------------------------------------------------------------
package sdd_pkg;

  // Angle outputs carry this many fractional bits of a degree.
  localparam int ANGLE_FRAC_BITS = 6;
  // Requested number of arctangent iterations; the table has 24 entries.
  localparam int ARCTAN_STAGES   = 16;
  localparam int ATAN_TABLE_LEN  = 24;
  localparam int CORDIC_N        = (ARCTAN_STAGES < ATAN_TABLE_LEN) ?
                                   ARCTAN_STAGES : ATAN_TABLE_LEN;

  // Internal angle accumulator is in 2^-16 degree; samples are scaled by 2^16.
  localparam int ACC_BITS    = 16;
  localparam int ANGLE_SHIFT = ACC_BITS - ANGLE_FRAC_BITS;

  localparam int SAMPLE_W  = 16;
  localparam int RADIAL_W  = 15;
  localparam int AXIAL_W   = 12;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_ANGLE_W = 15;
  // Axial zones are given in 1/64 degree whatever the output scale.
  localparam int AXIAL_FRAC_BITS = 6;

  // Vector width: sample, scaling, sign and CORDIC gain headroom.
  localparam int VEC_W = SAMPLE_W + ACC_BITS + 4;
  localparam int ZW    = 27;
  localparam int FULL_Z_INT = 360 << ACC_BITS;
  localparam int ZU_W  = $clog2(FULL_Z_INT);

  localparam int UNIT     = 1 << ANGLE_FRAC_BITS;
  localparam int FULL_OUT = 360 * UNIT;
  localparam int RAW_W    = $clog2(FULL_OUT + 1);
  localparam int CMP_W    = RAW_W + AXIAL_W + ANGLE_FRAC_BITS + AXIAL_FRAC_BITS;

  localparam logic signed [ZW-1:0] FULL_Z  = ZW'(FULL_Z_INT);
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(180 << ACC_BITS);
  localparam logic [ZU_W:0]        ROUND_HALF = (ZU_W + 1)'(1 << (ANGLE_SHIFT - 1));
  localparam logic [RAW_W-1:0]     FULL_ANGLE = RAW_W'(FULL_OUT);
  localparam logic [RAW_W-1:0]     OCT_SPAN   = RAW_W'(45 * UNIT);

  // Centers of the eight 45 degree sectors in output units.
  localparam logic [RAW_W-1:0] OCT_CENTER [8] = '{
    RAW_W'(0),         RAW_W'(45 * UNIT),  RAW_W'(90 * UNIT),  RAW_W'(135 * UNIT),
    RAW_W'(180 * UNIT), RAW_W'(225 * UNIT), RAW_W'(270 * UNIT), RAW_W'(315 * UNIT)
  };

  // arctan(2^-i) in 2^-16 degree, rounded to nearest.
  localparam logic signed [ZW-1:0] ATAN_DEG16 [ATAN_TABLE_LEN] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379), ZW'(117304),
    ZW'(58666),   ZW'(29335),   ZW'(14668),  ZW'(7334),   ZW'(3667),   ZW'(1833),
    ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),    ZW'(57),     ZW'(29),
    ZW'(14),      ZW'(7),       ZW'(4),      ZW'(2),      ZW'(1),      ZW'(0)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAIN_RADIAL = 3'd0,
    REG_C_RADIAL    = 3'd1,
    REG_PAD_RADIAL  = 3'd2,
    REG_MAIN_AXIAL  = 3'd3,
    REG_C_AXIAL     = 3'd4,
    REG_PAD_AXIAL   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STICK_MAIN = 2'd0,
    STICK_C    = 2'd1,
    STICK_PAD  = 2'd2
  } stick_sel_t;

  typedef struct packed {
    logic [2:0]                 player_tag;
    logic [1:0]                 stick_select;
    logic signed [SAMPLE_W-1:0] x_pos;
    logic signed [SAMPLE_W-1:0] y_pos;
  } sample_t;

  typedef struct packed {
    logic [2:0]             player_out;
    logic                   active;
    logic [OUT_ANGLE_W-1:0] raw_angle;
    logic [OUT_ANGLE_W-1:0] snapped_angle;
    logic [3:0]             dir4_mask;
    logic [7:0]             dir8_mask;
  } result_t;

endpackage

[rtl/stick_deadzone_direction_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_deadzone_direction_core
// Radial and axial dead zone, angle and direction masks for stick samples.
//
//   channel   direction  handshake                 payload
//   sample    in         sample_valid/sample_stall sample_t
//   result    out        result_valid/result_stall result_t
//   config    in         cfg_we                    cfg_index, cfg_data
//
// One transaction per clock is accepted and delivered while the skid register
// below is empty. The pipeline has one CORDIC iteration per stage plus entry,
// wrap, rounding, distance and output stages.
// A skid register behind the output stage takes one result when the result
// side stalls; the pipeline freezes only while it is full.
// Reset (rst, synchronous) clears the valid bits and loads the zone defaults.
// ----------------------------------------------------------------------------
module stick_deadzone_direction_core
  import sdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DIFF_S  = CORDIC_N + 3;
  localparam int LAST    = CORDIC_N + 4;

  // Configuration registers.
  logic [RADIAL_W-1:0] main_radial_zone, c_radial_zone, pad_radial_zone;
  logic [AXIAL_W-1:0]  main_axial_zone, c_axial_zone, pad_axial_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_radial_zone <= RADIAL_W'(5120);
      c_radial_zone    <= RADIAL_W'(5120);
      pad_radial_zone  <= RADIAL_W'(5120);
      main_axial_zone  <= AXIAL_W'(320);
      c_axial_zone     <= AXIAL_W'(320);
      pad_axial_zone   <= AXIAL_W'(320);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAIN_RADIAL: main_radial_zone <= cfg_data;
        REG_C_RADIAL:    c_radial_zone    <= cfg_data;
        REG_PAD_RADIAL:  pad_radial_zone  <= cfg_data;
        REG_MAIN_AXIAL:  main_axial_zone  <= cfg_data[AXIAL_W-1:0];
        REG_C_AXIAL:     c_axial_zone     <= cfg_data[AXIAL_W-1:0];
        REG_PAD_AXIAL:   pad_axial_zone   <= cfg_data[AXIAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic [LAST:0] vld;
  logic          skid_vld;
  logic          adv;
  result_t       res_pipe, res_skid;

  assign adv          = ~skid_vld;
  assign sample_stall = skid_vld;
  assign result_valid = skid_vld | vld[LAST];
  assign result       = skid_vld ? res_skid : res_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      skid_vld <= 1'b0;
    end else begin
      if (adv) begin
        vld <= {vld[LAST-1:0], sample_valid};
      end
      if (skid_vld) begin
        if (!result_stall) begin
          skid_vld <= 1'b0;
        end
      end else if (vld[LAST] && result_stall) begin
        skid_vld <= 1'b1;
      end
    end
  end

  // Stage registers.
  logic [2:0]                player [0:DIFF_S];
  logic [AXIAL_W-1:0]        axial  [0:DIFF_S];
  logic                      active [1:DIFF_S];
  logic [2*SAMPLE_W-2:0]     x_sq, y_sq;
  logic [2*RADIAL_W-1:0]     r_sq;
  logic signed [VEC_W-1:0]   u [0:CORDIC_N];
  logic signed [VEC_W-1:0]   v [0:CORDIC_N];
  logic signed [ZW-1:0]      z [0:CORDIC_N];
  logic [ZU_W-1:0]           z_mod;
  logic [RAW_W-1:0]          raw_round, raw_diff;
  logic [RAW_W-1:0]          oct_diff [8];

  // Entry stage: zone selection, squares and the left half-plane turn.
  logic [RADIAL_W-1:0]       sel_radial;
  logic [AXIAL_W-1:0]        sel_axial;
  logic signed [2*SAMPLE_W-1:0] x_sq_full, y_sq_full;
  logic [2*RADIAL_W-1:0]     r_sq_full;
  logic signed [VEC_W-1:0]   x_vec, y_vec, u_in, v_in;
  logic signed [ZW-1:0]      z_in;

  always_comb begin
    unique case (stick_sel_t'(sample.stick_select))
      STICK_C: begin
        sel_radial = c_radial_zone;
        sel_axial  = c_axial_zone;
      end
      STICK_PAD: begin
        sel_radial = pad_radial_zone;
        sel_axial  = pad_axial_zone;
      end
      default: begin
        sel_radial = main_radial_zone;
        sel_axial  = main_axial_zone;
      end
    endcase

    x_sq_full = sample.x_pos * sample.x_pos;
    y_sq_full = sample.y_pos * sample.y_pos;
    r_sq_full = sel_radial * sel_radial;

    x_vec = {{(VEC_W-SAMPLE_W-ACC_BITS){sample.x_pos[SAMPLE_W-1]}}, sample.x_pos,
             {ACC_BITS{1'b0}}};
    y_vec = {{(VEC_W-SAMPLE_W-ACC_BITS){sample.y_pos[SAMPLE_W-1]}}, sample.y_pos,
             {ACC_BITS{1'b0}}};
    // The rotated vector is (x, -y); the left half plane starts at 180 degrees.
    if (sample.x_pos[SAMPLE_W-1]) begin
      u_in = -x_vec;
      v_in = y_vec;
      z_in = HALF_Z;
    end else begin
      u_in = x_vec;
      v_in = -y_vec;
      z_in = '0;
    end
  end

  // Magnitude test, angle wrap, rounding and sector distances.
  logic [2*SAMPLE_W-1:0]   mag_sum;
  logic                    mag_active;
  logic signed [ZW-1:0]    z_wrap;
  logic [ZU_W:0]           round_sum;
  logic [RAW_W-1:0]        raw_pre, raw_next;
  logic [RAW_W-1:0]        diff_next [8];

  always_comb begin
    mag_sum    = {1'b0, x_sq} + {1'b0, y_sq};
    mag_active = mag_sum > {2'b00, r_sq};

    if (z[CORDIC_N] < 0) begin
      z_wrap = z[CORDIC_N] + FULL_Z;
    end else if (z[CORDIC_N] >= FULL_Z) begin
      z_wrap = z[CORDIC_N] - FULL_Z;
    end else begin
      z_wrap = z[CORDIC_N];
    end

    round_sum = {1'b0, z_mod} + ROUND_HALF;
    raw_pre   = RAW_W'(round_sum >> ANGLE_SHIFT);
    // A value that rounds up to a full turn reads as zero.
    raw_next  = (raw_pre >= FULL_ANGLE) ? '0 : raw_pre;

    for (int k = 0; k < 8; k++) begin
      diff_next[k] = (raw_round >= OCT_CENTER[k]) ? raw_round - OCT_CENTER[k] :
                                                    OCT_CENTER[k] - raw_round;
    end
  end

  // Output stage: circular distance, snapping and the direction masks.
  logic [RAW_W-1:0]        sect_dist [8];
  logic [RAW_W-1:0]        alt;
  logic [RAW_W-1:0]        snapped;
  logic [3:0]              dir4;
  logic [7:0]              dir8;
  result_t                 res_next;

  always_comb begin
    alt = '0;
    for (int k = 0; k < 8; k++) begin
      alt          = FULL_ANGLE - oct_diff[k];
      sect_dist[k] = (alt < oct_diff[k]) ? alt : oct_diff[k];
      dir8[k]      = {sect_dist[k], 1'b0} <= {1'b0, OCT_SPAN};
    end
    for (int j = 0; j < 4; j++) begin
      dir4[j] = sect_dist[2*j] <= OCT_SPAN;
    end
    // Walk from 270 down to 0 so that the lowest cardinal wins an overlap.
    snapped = raw_diff;
    for (int j = 3; j >= 0; j--) begin
      if ((CMP_W'(sect_dist[2*j]) << AXIAL_FRAC_BITS) <=
          (CMP_W'(axial[DIFF_S]) << ANGLE_FRAC_BITS)) begin
        snapped = OCT_CENTER[2*j];
      end
    end

    res_next.player_out    = player[DIFF_S];
    res_next.active        = active[DIFF_S];
    res_next.raw_angle     = active[DIFF_S] ? OUT_ANGLE_W'(raw_diff) : '0;
    res_next.snapped_angle = active[DIFF_S] ? OUT_ANGLE_W'(snapped) : '0;
    res_next.dir4_mask     = active[DIFF_S] ? dir4 : '0;
    res_next.dir8_mask     = active[DIFF_S] ? dir8 : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      player[0] <= sample.player_tag;
      axial[0]  <= sel_axial;
      x_sq      <= x_sq_full[2*SAMPLE_W-2:0];
      y_sq      <= y_sq_full[2*SAMPLE_W-2:0];
      r_sq      <= r_sq_full;
      u[0]      <= u_in;
      v[0]      <= v_in;
      z[0]      <= z_in;

      for (int s = 1; s <= DIFF_S; s++) begin
        player[s] <= player[s-1];
        axial[s]  <= axial[s-1];
      end
      active[1] <= mag_active;
      for (int s = 2; s <= DIFF_S; s++) begin
        active[s] <= active[s-1];
      end

      // One CORDIC iteration per stage; a non-negative v rotates clockwise.
      for (int s = 1; s <= CORDIC_N; s++) begin
        if (!v[s-1][VEC_W-1]) begin
          u[s] <= u[s-1] + (v[s-1] >>> (s - 1));
          v[s] <= v[s-1] - (u[s-1] >>> (s - 1));
          z[s] <= z[s-1] + ATAN_DEG16[s-1];
        end else begin
          u[s] <= u[s-1] - (v[s-1] >>> (s - 1));
          v[s] <= v[s-1] + (u[s-1] >>> (s - 1));
          z[s] <= z[s-1] - ATAN_DEG16[s-1];
        end
      end

      z_mod     <= z_wrap[ZU_W-1:0];
      raw_round <= raw_next;
      raw_diff  <= raw_round;
      oct_diff  <= diff_next;
      res_pipe  <= res_next;
    end

    if (!skid_vld && vld[LAST] && result_stall) begin
      res_skid <= res_pipe;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stick dead-zone and direction core. Stick
// samples are driven with random idle bursts, and every result is checked
// against a cycle-free model of the radial zone, the CORDIC angle, the
// cardinal snap and the direction masks. Zone registers are reprogrammed
// between phases, covering defaults, zeros, the nominal maxima and
// full-width values.
// ----------------------------------------------------------------------------
module tb;
  import sdd_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     LONG_HOLD      = 400;
  localparam int     REPORT_CAP     = 200;
  localparam int     CORDIC_STEPS   = 16;
  localparam int     FRAC_SHIFT     = 10;   // 2^-16 degree down to 1/64 degree
  localparam longint DEG            = 64;
  localparam longint FULL_TURN      = 360 * DEG;
  localparam longint FULL_Z16       = 360 * 65536;
  localparam logic [1:0] STICK_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // arctan(2^-i) in 2^-16 degree
  longint arctan_deg16 [0:15] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic [14:0] radial_zone [3];
  logic [11:0] axial_zone [3];

  sample_t samples_to_send [$];
  result_t predicted_results [$];
  int      mismatch_count = 0;
  int      send_odds = 0;
  int      recv_odds = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      hold_left = 0;
  bit      hold_off_req = 1'b0;
  int      quiet_cycles = 0;

  stick_deadzone_direction_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Selector three has no stick of its own and falls back to the main zones.
  function automatic int zone_index(logic [1:0] sel);
    if (sel == STICK_C) return 1;
    if (sel == STICK_PAD) return 2;
    return 0;
  endfunction

  function automatic longint circ_dist(longint a, longint c);
    longint d;
    d = (a > c) ? a - c : c - a;
    if (FULL_TURN - d < d) d = FULL_TURN - d;
    return d;
  endfunction

  function automatic result_t predict_direction(sample_t s);
    result_t r;
    longint  x, y, u, v, t, z, radial, axial, raw, snapped;
    bit      found;
    x = longint'($signed(s.x_pos));
    y = longint'($signed(s.y_pos));
    radial = longint'(radial_zone[zone_index(s.stick_select)]);
    axial = longint'(axial_zone[zone_index(s.stick_select)]);
    r = '0;
    r.player_out = s.player_tag;
    if (x * x + y * y > radial * radial) begin
      r.active = 1'b1;
      u = x * 65536;
      v = -y * 65536;
      z = 0;
      // The left half plane is turned by 180 degrees before rotating.
      if (u < 0) begin
        u = -u;
        v = -v;
        z = 180 * 65536;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        t = u;
        if (v >= 0) begin
          u = u + (v >>> i);
          v = v - (t >>> i);
          z = z + arctan_deg16[i];
        end else begin
          u = u - (v >>> i);
          v = v + (t >>> i);
          z = z - arctan_deg16[i];
        end
      end
      while (z < 0) z = z + FULL_Z16;
      while (z >= FULL_Z16) z = z - FULL_Z16;
      raw = (z + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (raw >= FULL_TURN) raw = 0;
      // Snap windows are tried from 0 degrees upward; the first hit wins.
      snapped = raw;
      found = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (!found && circ_dist(raw, 90 * k * DEG) * 64 <= axial * DEG) begin
          snapped = 90 * k * DEG;
          found = 1'b1;
        end
      end
      for (int k = 0; k < 4; k++)
        if (circ_dist(raw, 90 * k * DEG) <= 45 * DEG) r.dir4_mask[k] = 1'b1;
      for (int k = 0; k < 8; k++)
        if (circ_dist(raw, 45 * k * DEG) * 2 <= 45 * DEG) r.dir8_mask[k] = 1'b1;
      r.raw_angle = 15'(raw);
      r.snapped_angle = 15'(snapped);
    end
    return r;
  endfunction

  function automatic sample_t make_sample(int tag, logic [1:0] sel, int x, int y);
    sample_t s;
    s.player_tag = 3'(tag);
    s.stick_select = sel;
    s.x_pos = 16'(x);
    s.y_pos = 16'(y);
    return s;
  endfunction

  function automatic sample_t random_sample();
    logic [1:0] sel;
    int         x, y, big, minor;
    sel = ($urandom_range(0, 9) == 0) ? STICK_UNUSED : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
      end
      1, 2, 3: begin
        x = int'($urandom_range(0, 51200)) - 25600;
        y = int'($urandom_range(0, 51200)) - 25600;
      end
      4, 5: begin
        // Just inside, on and just outside the radial zone along an axis.
        big = int'(radial_zone[zone_index(sel)]) + int'($urandom_range(0, 4)) - 2;
        minor = int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) begin
          x = big;
          y = minor;
        end else begin
          x = minor;
          y = big;
        end
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
      end
      6, 7: begin
        // Slightly off a cardinal axis, around the snap window edges.
        big = $urandom_range(256, 25600);
        minor = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 1)) big = -big;
        if ($urandom_range(0, 1)) begin
          x = big;
          y = minor;
        end else begin
          x = minor;
          y = big;
        end
      end
      8: begin
        big = $urandom_range(0, 25600);
        x = $urandom_range(0, 1) ? big : -big;
        y = $urandom_range(0, 1) ? big : -big;
      end
      default: begin
        x = int'($urandom_range(0, 32)) - 16;
        y = int'($urandom_range(0, 32)) - 16;
      end
    endcase
    return make_sample($urandom_range(0, 7), sel, x, y);
  endfunction

  function automatic logic [14:0] pick_radial();
    if ($urandom_range(0, 7) == 0) return 15'($urandom_range(25601, 32767));
    return 15'($urandom_range(0, 25600));
  endfunction

  function automatic logic [14:0] pick_axial();
    // Upper data bits beyond the register width must be dropped by the block.
    if ($urandom_range(0, 7) == 0) return 15'($urandom_range(0, 32767));
    return 15'($urandom_range(0, 2880));
  endfunction

  task automatic queue_random(int count);
    repeat (count) samples_to_send.push_back(random_sample());
  endtask

  task automatic write_zone(cfg_reg_t idx, logic [14:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MAIN_RADIAL: radial_zone[0] = value;
      REG_C_RADIAL:    radial_zone[1] = value;
      REG_PAD_RADIAL:  radial_zone[2] = value;
      REG_MAIN_AXIAL:  axial_zone[0] = value[11:0];
      REG_C_AXIAL:     axial_zone[1] = value[11:0];
      REG_PAD_AXIAL:   axial_zone[2] = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_zones(logic [14:0] r_main, logic [14:0] r_c, logic [14:0] r_pad,
                           logic [14:0] a_main, logic [14:0] a_c, logic [14:0] a_pad);
    write_zone(REG_MAIN_RADIAL, r_main);
    write_zone(REG_C_RADIAL, r_c);
    write_zone(REG_PAD_RADIAL, r_pad);
    write_zone(REG_MAIN_AXIAL, a_main);
    write_zone(REG_C_AXIAL, a_c);
    write_zone(REG_PAD_AXIAL, a_pad);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || sample_valid || predicted_results.size() != 0);
  endtask

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin : sample_driver
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sample_valid && !sample_stall)
        predicted_results.push_back(predict_direction(sample));
      // A stalled transaction stays on the bus unchanged.
      if (!(sample_valid && sample_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (samples_to_send.size() == 0) begin
          sample_valid <= 1'b0;
        end else if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
          send_gap = $urandom_range(0, 17);
          sample_valid <= 1'b0;
        end else begin
          sample_valid <= 1'b1;
          sample <= samples_to_send.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $error("result transaction with no prediction pending");
        end else begin
          want = predicted_results.pop_front();
          check_field("player_out", want.player_out, result.player_out);
          check_field("active", want.active, result.active);
          check_field("raw_angle", want.raw_angle, result.raw_angle);
          check_field("snapped_angle", want.snapped_angle, result.snapped_angle);
          check_field("dir4_mask", want.dir4_mask, result.dir4_mask);
          check_field("dir8_mask", want.dir8_mask, result.dir8_mask);
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
        recv_gap = $urandom_range(0, 17);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 3; i++) begin
      radial_zone[i] = 15'd5120;
      axial_zone[i] = 12'd320;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed samples under the reset zones.
    send_odds = 5;
    recv_odds = 5;
    samples_to_send.push_back(make_sample(0, STICK_MAIN, 0, 0));
    samples_to_send.push_back(make_sample(1, STICK_MAIN, 5120, 0));
    samples_to_send.push_back(make_sample(2, STICK_MAIN, 5121, 0));
    samples_to_send.push_back(make_sample(3, STICK_C, 0, -25600));
    samples_to_send.push_back(make_sample(4, STICK_PAD, -25600, 0));
    samples_to_send.push_back(make_sample(5, STICK_MAIN, 0, 25600));
    samples_to_send.push_back(make_sample(6, STICK_MAIN, 25600, -25600));
    samples_to_send.push_back(make_sample(7, STICK_C, -25600, -25600));
    samples_to_send.push_back(make_sample(0, STICK_PAD, -25600, 25600));
    samples_to_send.push_back(make_sample(1, STICK_MAIN, 25600, 25600));
    // A hair below the positive x axis rounds to a full turn and wraps to zero.
    samples_to_send.push_back(make_sample(2, STICK_UNUSED, 25600, 1));
    samples_to_send.push_back(make_sample(3, STICK_MAIN, -32768, -32768));
    samples_to_send.push_back(make_sample(4, STICK_MAIN, 32767, 32767));
    samples_to_send.push_back(make_sample(5, STICK_MAIN, -32768, 0));
    samples_to_send.push_back(make_sample(6, STICK_MAIN, 32767, -32768));
    samples_to_send.push_back(make_sample(7, STICK_C, 25600, -2240));
    samples_to_send.push_back(make_sample(0, STICK_C, 25600, -2250));
    samples_to_send.push_back(make_sample(1, STICK_PAD, 25600, -10604));
    samples_to_send.push_back(make_sample(2, STICK_MAIN, -25600, -1));
    samples_to_send.push_back(make_sample(3, STICK_UNUSED, 100, 5000));
    samples_to_send.push_back(make_sample(4, STICK_MAIN, -1, -25600));
    queue_random(220);
    wait_drained();

    // Zero zones: everything but the zero vector is active and nothing snaps
    // except exact cardinals.
    set_zones(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
    send_odds = 3;
    recv_odds = 12;
    queue_random(200);
    wait_drained();

    // Nominal maxima; the result side holds off long enough to back up the
    // pipeline while samples keep coming.
    set_zones(15'd25600, 15'd25600, 15'd25600, 15'd2880, 15'd2880, 15'd2880);
    send_odds = 0;
    recv_odds = 8;
    hold_off_req = 1'b1;
    queue_random(200);
    wait_drained();

    set_zones(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_odds = 10;
    recv_odds = 3;
    queue_random(200);
    wait_drained();

    repeat (4) begin
      set_zones(pick_radial(), pick_radial(), pick_radial(),
                pick_axial(), pick_axial(), pick_axial());
      case ($urandom_range(0, 3))
        0: send_odds = 0;
        1: send_odds = 3;
        2: send_odds = 8;
        default: send_odds = 20;
      endcase
      case ($urandom_range(0, 3))
        0: recv_odds = 0;
        1: recv_odds = 3;
        2: recv_odds = 8;
        default: recv_odds = 20;
      endcase
      queue_random(220);
      wait_drained();
    end

    // Closing stretch at full rate on both sides.
    set_zones(pick_radial(), pick_radial(), pick_radial(),
              pick_axial(), pick_axial(), pick_axial());
    send_odds = 0;
    recv_odds = 0;
    queue_random(200);
    wait_drained();

    repeat (30) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[stick_deadzone_direction_core.f]
rtl/sdd_pkg.sv
rtl/stick_deadzone_direction_core.sv
tb/sv/tb.sv
